### src/sle_pkg.sv
// Package with the shared types and codes of the sorted list engine.
`default_nettype none

package sle_pkg;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef logic [FUNC_W-1:0]          func_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [POS_W-1:0]           position_t;
    typedef logic [COUNT_W-1:0]         count_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic compare;
        logic apply;
    } sle_cmd_t;

endpackage

`default_nettype wire

### src/sle_ifs.sv
// Interfaces for the request and response channels of the sorted list engine.
`default_nettype none

interface sle_req_if
    import sle_pkg::*;
();
    logic   valid;
    logic   ready;
    func_t  func;
    value_t value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface sle_rsp_if
    import sle_pkg::*;
();
    logic      valid;
    logic      ready;
    status_t   status;
    position_t position;
    count_t    count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink   (input valid, input status, input position, input count, output ready);
endinterface

`default_nettype wire

### src/sle_ctrl.sv
// Controller state machine that sequences capture, compare and apply of each item.
`default_nettype none

module sle_ctrl
    import sle_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output sle_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_COMPARE = 2'd1;
    localparam logic [1:0] S_APPLY   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        if (res_valid_reg && out_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = S_APPLY;
            end
            S_APPLY:
            begin
                // The result register must be free before it is loaded again.
                if (!res_valid_reg || out_ready)
                begin
                    cmd.apply      = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign out_valid = res_valid_reg;

endmodule

`default_nettype wire

### src/sle_datapath.sv
// Datapath: row of list cells, per-cell comparators, position encoder and result register.
`default_nettype none

module sle_datapath
    import sle_pkg::*;
#(
    parameter int LIST_DEPTH = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire sle_cmd_t cmd,
    input  wire func_t    in_func,
    input  wire value_t   in_value,
    output status_t       res_status,
    output position_t     res_position,
    output count_t        res_count
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    func_t           func_reg;
    value_t          value_reg;
    value_t          entry_reg [LIST_DEPTH];
    value_t          entry_next [LIST_DEPTH];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [LIST_DEPTH-1:0] gt_reg;
    logic [LIST_DEPTH-1:0] eq_reg;
    logic [LIST_DEPTH-1:0] gt_cmp;
    logic [LIST_DEPTH-1:0] eq_cmp;
    logic [CW-1:0]   pos;
    logic            found;
    logic            full;
    status_t         status_next;
    logic [CW-1:0]   pos_next;
    status_t         status_reg;
    position_t       position_reg;
    count_t          res_count_reg;

    // Each cell compares its own entry against the operand; cells past the fill are masked.
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            gt_cmp[i] = (CW'(i) < count_reg) && (entry_reg[i] > value_reg);
            eq_cmp[i] = (CW'(i) < count_reg) && (entry_reg[i] == value_reg);
        end
    end

    // The list is descending, so the greater-than flags form a prefix. Its length is
    // both the insert slot and the index of the first equal entry.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < LIST_DEPTH - 1; i++)
        begin
            if (gt_reg[i] && !gt_reg[i+1])
            begin
                pos = pos | CW'(i + 1);
            end
        end
        if (gt_reg[LIST_DEPTH-1])
        begin
            pos = pos | CW'(LIST_DEPTH);
        end
    end

    assign found = |eq_reg;
    assign full  = (count_reg == CW'(LIST_DEPTH));

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        count_next  = count_reg;
        status_next = ST_OK;
        pos_next    = pos;
        if (func_reg == FN_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
                pos_next    = '0;
            end
            else
            begin
                for (int i = 0; i < LIST_DEPTH; i++)
                begin
                    if (CW'(i) == pos)
                    begin
                        entry_next[i] = value_reg;
                    end
                    else if (i > 0 && CW'(i) > pos)
                    begin
                        entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                count_next = count_reg + CW'(1);
            end
        end
        else if (func_reg == FN_REMOVE)
        begin
            if (found)
            begin
                for (int i = 0; i < LIST_DEPTH - 1; i++)
                begin
                    if (CW'(i) >= pos)
                    begin
                        entry_next[i] = entry_reg[i+1];
                    end
                end
                count_next = count_reg - CW'(1);
            end
            else
            begin
                status_next = ST_NOT_FOUND;
                pos_next    = '0;
            end
        end
        else
        begin
            // Search, and the unused selector code, which behaves as a search.
            if (!found)
            begin
                status_next = ST_NOT_FOUND;
                pos_next    = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= in_func;
            value_reg <= in_value;
        end
        if (cmd.compare)
        begin
            gt_reg <= gt_cmp;
            eq_reg <= eq_cmp;
        end
        if (cmd.apply)
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
            status_reg    <= status_next;
            position_reg  <= POS_W'(pos_next);
            res_count_reg <= COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.apply)
        begin
            count_reg <= count_next;
        end
    end

    assign res_status   = status_reg;
    assign res_position = position_reg;
    assign res_count    = res_count_reg;

endmodule

`default_nettype wire

### src/sorted_list_engine.sv
// Top level of the sorted list engine: a descending list with insert, remove and search.
`default_nettype none

// Channel | Direction | Payload                              | Handshake
// req     | in        | func (2b), value (32b signed)        | valid / ready
// rsp     | out       | status (2b), position (4b), count (5b) | valid / ready
//
// Each item passes three steps: capture, compare, in which every list cell compares
// its entry against the operand in parallel, and apply, which shifts the row of cells
// and loads the result register. No new item is taken until apply is done.
// Reset empties the list at once; the cell contents are not cleared.
// A result waiting on rsp does not block the next item; only the apply step of that
// next item waits until the result register has been taken.
module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int LIST_DEPTH = 16
)
(
    input wire logic clk,
    input wire logic rst_n,
    sle_req_if.sink  req,
    sle_rsp_if.source rsp
);

    sle_cmd_t cmd;

    // The controller owns the handshakes and the pacing of the datapath.
    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // The datapath holds the list cells, the entry count and the result payload.
    sle_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_func      (req.func),
        .in_value     (req.value),
        .res_status   (rsp.status),
        .res_position (rsp.position),
        .res_count    (rsp.count)
    );

endmodule

`default_nettype wire

### tb/sv/sle_list_checker.sv
// Checker for the sorted list engine: predicts every result item and compares it.
`timescale 1ns / 100ps

module sle_list_checker
    import sle_pkg::*;
#(
    parameter int LIST_DEPTH = 16
)
(
    input wire logic clk,
    input wire logic rst_n,
    sle_req_if       req,
    sle_rsp_if       rsp,
    output int       fail_count,
    output int       outstanding
);

    typedef struct packed {
        status_t   status;
        position_t position;
        count_t    count;
    } list_result_t;

    // Shadow of the list, head at index 0, kept in descending order.
    value_t       shadow_list [LIST_DEPTH];
    int           shadow_len;
    list_result_t result_q [$];
    list_result_t want;
    int           mismatches;

    // Index of the first entry equal to v, or -1 when there is none.
    function automatic int find_entry(value_t v);
        int i;
        for (i = 0; i < shadow_len; i++) begin
            if (shadow_list[i] == v) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one operation to the shadow list and returns the result it causes.
    function automatic list_result_t apply_operation(func_t f, value_t v);
        list_result_t r;
        int           slot;
        int           i;
        r.status   = ST_OK;
        r.position = '0;
        slot       = -1;
        if (f == FN_INSERT) begin
            if (shadow_len >= LIST_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // The new value goes ahead of the first entry not greater than it.
                slot = shadow_len;
                for (i = shadow_len - 1; i >= 0; i--) begin
                    if (shadow_list[i] <= v) begin
                        slot = i;
                    end
                end
                for (i = shadow_len; i > slot; i--) begin
                    shadow_list[i] = shadow_list[i - 1];
                end
                shadow_list[slot] = v;
                shadow_len++;
                r.position = position_t'(slot);
            end
        end else if (f == FN_REMOVE) begin
            slot = find_entry(v);
            if (slot < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                for (i = slot; i + 1 < shadow_len; i++) begin
                    shadow_list[i] = shadow_list[i + 1];
                end
                shadow_len--;
                r.position = position_t'(slot);
            end
        end else begin
            // Search, and the unused selector, which behaves as a search.
            slot = find_entry(v);
            if (slot < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.position = position_t'(slot);
            end
        end
        r.count = count_t'(shadow_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow_len = 0;
            mismatches = 0;
            result_q.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end else begin
            // A result item never belongs to a request item taken at the same edge.
            if (rsp.valid && rsp.ready) begin
                if (result_q.size() == 0) begin
                    $error("result item with no request item waiting for it");
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.position !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, rsp.position);
                        mismatches++;
                    end
                    if (rsp.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, rsp.count);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready) begin
                result_q.push_back(apply_operation(req.func, req.value));
            end
            fail_count  <= mismatches;
            outstanding <= result_q.size();
        end
    end

endmodule

### tb/sv/tb_sorted_list_engine.sv
// Testbench top for the sorted list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_sorted_list_engine;
    import sle_pkg::*;

    localparam int LIST_DEPTH = 16;

    // The selector value that has no operation of its own; the block treats it as a search.
    localparam func_t FN_SPARE = 2'd3;

    localparam value_t VALUE_MIN = 32'sh8000_0000;
    localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;

    // Random part: epochs alternate between growing the list and shrinking it.
    localparam int EPOCHS      = 15;
    localparam int EPOCH_ITEMS = 128;
    localparam int POOL_SIZE   = 8;

    // Every result item is back before the tail starts, so a short tail is plenty.
    localparam int TAIL_CYCLES   = 20;
    localparam int LONG_HOLD     = 500;
    localparam int WATCHDOG_IDLE = 3000;

    logic clk;
    logic rst_n;

    sle_req_if req_if ();
    sle_rsp_if rsp_if ();

    int fail_count;
    int outstanding;

    // When calm is set neither side inserts idle cycles.
    bit calm;

    // The stimulus asks for a long receiver hold-off by bumping holds_asked; the
    // receiver counts the hold-off out in its own process.
    int holds_asked;

    value_t key_pool [POOL_SIZE];
    value_t corner_values [4];

    sorted_list_engine #(
        .LIST_DEPTH(LIST_DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    sle_list_checker #(
        .LIST_DEPTH(LIST_DEPTH)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #5 clk = ~clk;
        end
    end

    // Offers one request item and returns at the edge where it is taken. The idle
    // loop and the final assignment never hit the same time step, so valid gets at
    // most one nonblocking update per step.
    task automatic offer_item(func_t f, value_t v);
        while (!calm && $urandom_range(99) < 17) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.func  <= f;
        req_if.value <= v;
        do begin
            @(posedge clk);
        end while (!req_if.ready);
    endtask

    // Stops offering until every predicted result item has come back.
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
    endtask

    // Growing epochs favor inserts so the list fills and hits the full case;
    // shrinking epochs favor removes so it empties again. The spare selector
    // shows up now and then in both.
    function automatic func_t pick_func(bit growing);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) begin
            return FN_SPARE;
        end
        if (r < (growing ? 58 : 25)) begin
            return FN_INSERT;
        end
        if (r < (growing ? 80 : 72)) begin
            return FN_REMOVE;
        end
        return FN_SEARCH;
    endfunction

    // Most values come from a small pool so that duplicates pile up and removes and
    // searches usually hit. Neighbors of pool values exercise the ordering, and
    // fully random words make sure every bit of the value toggles.
    function automatic value_t pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) begin
            return corner_values[$urandom_range(3)];
        end
        if (r < 30) begin
            return value_t'($urandom);
        end
        if (r < 40) begin
            return key_pool[$urandom_range(POOL_SIZE - 1)] + value_t'(1);
        end
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // Receiver: random back-pressure, plus the long hold-off on request.
    initial begin
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left  = 0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(99) < 17) begin
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that accepts nothing on either channel for too long is hung.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_IDLE) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // Reset, stimulus and verdict.
    initial begin
        int epoch;
        int n;
        int i;
        corner_values[0] = VALUE_MIN;
        corner_values[1] = VALUE_MAX;
        corner_values[2] = '0;
        corner_values[3] = -1;
        calm        = 1'b0;
        holds_asked = 0;
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.func  <= FN_SEARCH;
        req_if.value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Searching and removing on an empty list must miss.
        offer_item(FN_SEARCH, 0);
        offer_item(FN_REMOVE, 5);
        // Both extremes, zero, a duplicate of zero and minus one; the duplicate
        // must land ahead of its equal.
        offer_item(FN_INSERT, VALUE_MAX);
        offer_item(FN_INSERT, VALUE_MIN);
        offer_item(FN_INSERT, 0);
        offer_item(FN_INSERT, 0);
        offer_item(FN_INSERT, -1);
        offer_item(FN_SEARCH, 0);
        // The spare selector must act as a search and leave the list alone.
        offer_item(FN_SPARE, VALUE_MIN);
        offer_item(FN_REMOVE, 0);
        offer_item(FN_REMOVE, 123);
        // Four entries are left; twelve more fill the list to capacity.
        for (n = 0; n < LIST_DEPTH - 4; n++) begin
            offer_item(FN_INSERT, value_t'($urandom));
        end
        // An insert into a full list is refused and changes nothing.
        offer_item(FN_INSERT, 7);
        offer_item(FN_REMOVE, VALUE_MIN);
        offer_item(FN_SEARCH, VALUE_MAX);
        wait_for_drain();

        // Random part. Outstanding results are drained between epochs, so every epoch
        // also gives the sender a pause until all results are back.
        for (epoch = 0; epoch < EPOCHS; epoch++) begin
            calm = (epoch == 6);
            for (i = 0; i < POOL_SIZE; i++) begin
                if ($urandom_range(1) == 1) begin
                    key_pool[i] = value_t'($urandom);
                end else begin
                    key_pool[i] = value_t'($urandom_range(40)) - value_t'(20);
                end
            end
            for (n = 0; n < EPOCH_ITEMS; n++) begin
                // The receiver stops for a long time while the sender keeps
                // offering, so the block backs up and stalls its input.
                if ((epoch == 3 || epoch == 11) && n == 40) begin
                    holds_asked++;
                end
                offer_item(pick_func(epoch % 2 == 0), pick_value());
            end
            wait_for_drain();
        end
        calm = 1'b0;

        // Anything that shows up now is a result item nobody asked for.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
src/sle_pkg.sv
src/sle_ifs.sv
src/sle_ctrl.sv
src/sle_datapath.sv
src/sorted_list_engine.sv
tb/sv/sle_list_checker.sv
tb/sv/tb_sorted_list_engine.sv
